// ===== sv/a64dp_pkg.sv =====
// Shared types, encodings and helpers for the AArch64 data-processing (register) decoder.
// Used by every stage module and by the top level; depends on nothing.
`default_nettype none

package a64dp_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNSUP   = 2'd1,
        ST_UNALLOC = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        GRP_NONE,
        GRP_LOGICAL,
        GRP_ADDSUB_SH,
        GRP_ADDSUB_EXT,
        GRP_CARRY,
        GRP_COND_CMP,
        GRP_COND_SEL,
        GRP_ONE_SRC,
        GRP_TWO_SRC,
        GRP_THREE_SRC
    } t_grp;

    // Operand fields that a decoded instruction drives
    typedef struct packed {
        logic rd;
        logic rm;
        logic ra;
        logic shift;
        logic ext;
        logic cond;
        logic nzcv;
    } t_fsel;

    // Bits 28..24 of the major groups
    localparam logic [4:0] MAJ_LOGICAL = 5'b01010;
    localparam logic [4:0] MAJ_ADDSUB  = 5'b01011;
    localparam logic [4:0] MAJ_DP_MISC = 5'b11010;
    localparam logic [4:0] MAJ_3SRC    = 5'b11011;

    // Bits 23..21 inside the miscellaneous group
    localparam logic [2:0] SUB_CARRY    = 3'b000;
    localparam logic [2:0] SUB_COND_CMP = 3'b010;
    localparam logic [2:0] SUB_COND_SEL = 3'b100;
    localparam logic [2:0] SUB_DP_SRC   = 3'b110;

    localparam logic [5:0] OP2_UDIV   = 6'h02;
    localparam logic [5:0] OP2_LSLV   = 6'h08;
    localparam logic [5:0] OP2_CRC_LO = 6'h10;
    localparam logic [5:0] OP1_REV64  = 6'h03;
    localparam logic [5:0] OP1_LAST   = 6'h08;

    localparam logic [2:0] OP3_MADD   = 3'd0;
    localparam logic [2:0] OP3_SMADDL = 3'd1;
    localparam logic [2:0] OP3_SMULH  = 3'd2;
    localparam logic [2:0] OP3_RSVD   = 3'd3;
    localparam logic [2:0] OP3_UMADDL = 3'd5;
    localparam logic [2:0] OP3_UMULH  = 3'd6;

    localparam logic [5:0] ID_COND_CMP_BASE   = 6'd0;
    localparam logic [5:0] ID_COND_SEL_BASE   = 6'd4;
    localparam logic [5:0] ID_LOGICAL_BASE    = 6'd8;
    localparam logic [5:0] ID_ADDSUB_SH_BASE  = 6'd16;
    localparam logic [5:0] ID_ADDSUB_EXT_BASE = 6'd20;
    localparam logic [5:0] ID_CARRY_BASE      = 6'd24;
    localparam logic [5:0] ID_DIV_BASE        = 6'd28;
    localparam logic [5:0] ID_SHIFTV_BASE     = 6'd30;
    localparam logic [5:0] ID_CRC_BASE        = 6'd34;
    localparam logic [5:0] ID_ONE_SRC_BASE    = 6'd46;
    localparam logic [5:0] ID_MSUB            = 6'd55;
    localparam logic [5:0] ID_MADD            = 6'd56;
    localparam logic [5:0] ID_SMSUBL          = 6'd57;
    localparam logic [5:0] ID_SMADDL          = 6'd58;
    localparam logic [5:0] ID_SMULH           = 6'd59;
    localparam logic [5:0] ID_UMSUBL          = 6'd60;
    localparam logic [5:0] ID_UMADDL          = 6'd61;
    localparam logic [5:0] ID_UMULH           = 6'd62;
    localparam logic [5:0] ID_NONE            = 6'd63;

    localparam logic [4:0] REG_ZR = 5'd31;

    // Two-source opcodes: divides, variable shifts, CRC and min/max
    function automatic logic two_src_known(input logic [5:0] op);
        logic div_op;
        logic shv_op;
        logic crc_mm;
        div_op = (op[5:1] == OP2_UDIV[5:1]);
        shv_op = (op[5:2] == OP2_LSLV[5:2]);
        crc_mm = (op[5:4] == OP2_CRC_LO[5:4]) && (op[3:2] != 2'b11);
        return div_op || shv_op || crc_mm;
    endfunction

endpackage

`default_nettype wire

// ===== sv/a64dp_classify.sv =====
// First stage: sorts the instruction word into its group and checks the group's fixed bits.
// Depends on a64dp_pkg.
`default_nettype none

module a64dp_classify (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_word,
    output logic                   o_valid,
    output logic [31:0]            o_word,
    output a64dp_pkg::t_grp        o_grp,
    output logic                   o_fixed_ok
);

    logic                r_valid;
    logic [31:0]         r_word;
    a64dp_pkg::t_grp     r_grp;
    logic                r_fixed_ok;
    a64dp_pkg::t_grp     n_grp;
    logic                n_fixed_ok;

    always_comb begin
        n_grp      = a64dp_pkg::GRP_NONE;
        n_fixed_ok = 1'b1;
        case (i_word[28:24])
            a64dp_pkg::MAJ_LOGICAL: begin
                n_grp = a64dp_pkg::GRP_LOGICAL;
            end
            a64dp_pkg::MAJ_ADDSUB: begin
                n_grp = i_word[21] ? a64dp_pkg::GRP_ADDSUB_EXT : a64dp_pkg::GRP_ADDSUB_SH;
            end
            a64dp_pkg::MAJ_DP_MISC: begin
                case (i_word[23:21])
                    a64dp_pkg::SUB_CARRY: begin
                        n_grp      = a64dp_pkg::GRP_CARRY;
                        n_fixed_ok = (i_word[15:10] == 6'd0);
                    end
                    a64dp_pkg::SUB_COND_CMP: begin
                        n_grp      = a64dp_pkg::GRP_COND_CMP;
                        n_fixed_ok = i_word[29] && !i_word[10] && !i_word[4];
                    end
                    a64dp_pkg::SUB_COND_SEL: begin
                        n_grp      = a64dp_pkg::GRP_COND_SEL;
                        n_fixed_ok = !i_word[29];
                    end
                    a64dp_pkg::SUB_DP_SRC: begin
                        if (i_word[30]) begin
                            n_grp      = a64dp_pkg::GRP_ONE_SRC;
                            n_fixed_ok = !i_word[29] && (i_word[20:16] == 5'd0)
                                         && (i_word[15:10] <= a64dp_pkg::OP1_LAST);
                        end else begin
                            n_grp      = a64dp_pkg::GRP_TWO_SRC;
                            n_fixed_ok = !i_word[29]
                                         && a64dp_pkg::two_src_known(i_word[15:10]);
                        end
                    end
                    default: begin
                        n_grp = a64dp_pkg::GRP_NONE;
                    end
                endcase
            end
            a64dp_pkg::MAJ_3SRC: begin
                n_grp      = a64dp_pkg::GRP_THREE_SRC;
                n_fixed_ok = (i_word[30:29] == 2'b00);
            end
            default: begin
                n_grp = a64dp_pkg::GRP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word     <= i_word;
            r_grp      <= n_grp;
            r_fixed_ok <= n_fixed_ok;
        end
    end

    assign o_valid    = r_valid;
    assign o_word     = r_word;
    assign o_grp      = r_grp;
    assign o_fixed_ok = r_fixed_ok;

endmodule

`default_nettype wire

// ===== sv/a64dp_decode.sv =====
// Second stage: applies the reserved-encoding checks and forms status, number and field selects.
// Depends on a64dp_pkg; fed by a64dp_classify.
`default_nettype none

module a64dp_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_word,
    input  wire a64dp_pkg::t_grp   i_grp,
    input  wire logic              i_fixed_ok,
    output logic                   o_valid,
    output logic [31:0]            o_word,
    output a64dp_pkg::t_status     o_status,
    output logic [5:0]             o_id,
    output a64dp_pkg::t_fsel       o_sel
);

    logic                  r_valid;
    logic [31:0]           r_word;
    a64dp_pkg::t_status    r_status;
    logic [5:0]            r_id;
    a64dp_pkg::t_fsel      r_sel;
    a64dp_pkg::t_status    n_status;
    logic [5:0]            n_id;
    a64dp_pkg::t_fsel      n_sel;

    logic       sf;
    logic       wide_shift;
    logic [5:0] op6;
    logic [2:0] op3;
    logic       o0;
    logic       acc_zr;
    logic       crc_grp;
    logic       crc64;

    assign sf         = i_word[31];
    assign wide_shift = !sf && i_word[15];
    assign op6        = i_word[15:10];
    assign op3        = i_word[23:21];
    assign o0         = i_word[15];
    assign acc_zr     = (i_word[14:10] == a64dp_pkg::REG_ZR);
    assign crc_grp    = (op6[5:3] == a64dp_pkg::OP2_CRC_LO[5:3]);
    assign crc64      = crc_grp && (op6[1:0] == 2'b11);

    always_comb begin
        n_status = a64dp_pkg::ST_UNSUP;
        n_id     = a64dp_pkg::ID_NONE;
        n_sel    = '0;
        if (i_fixed_ok) begin
            case (i_grp)
                a64dp_pkg::GRP_LOGICAL: begin
                    if (wide_shift) begin
                        n_status = a64dp_pkg::ST_UNALLOC;
                    end else begin
                        n_status  = a64dp_pkg::ST_OK;
                        n_id      = a64dp_pkg::ID_LOGICAL_BASE
                                    + {3'b000, i_word[30:29], i_word[21]};
                        n_sel.rd    = 1'b1;
                        n_sel.rm    = 1'b1;
                        n_sel.shift = 1'b1;
                    end
                end
                a64dp_pkg::GRP_ADDSUB_SH: begin
                    if (i_word[23:22] == 2'b11 || wide_shift) begin
                        n_status = a64dp_pkg::ST_UNALLOC;
                    end else begin
                        n_status    = a64dp_pkg::ST_OK;
                        n_id        = a64dp_pkg::ID_ADDSUB_SH_BASE + {4'b0000, i_word[30:29]};
                        n_sel.rd    = 1'b1;
                        n_sel.rm    = 1'b1;
                        n_sel.shift = 1'b1;
                    end
                end
                a64dp_pkg::GRP_ADDSUB_EXT: begin
                    if (i_word[23:22] != 2'b00 || i_word[12:10] > 3'd4) begin
                        n_status = a64dp_pkg::ST_UNALLOC;
                    end else begin
                        n_status  = a64dp_pkg::ST_OK;
                        n_id      = a64dp_pkg::ID_ADDSUB_EXT_BASE + {4'b0000, i_word[30:29]};
                        n_sel.rd  = 1'b1;
                        n_sel.rm  = 1'b1;
                        n_sel.ext = 1'b1;
                    end
                end
                a64dp_pkg::GRP_CARRY: begin
                    n_status = a64dp_pkg::ST_OK;
                    n_id     = a64dp_pkg::ID_CARRY_BASE + {4'b0000, i_word[30:29]};
                    n_sel.rd = 1'b1;
                    n_sel.rm = 1'b1;
                end
                a64dp_pkg::GRP_COND_CMP: begin
                    n_status   = a64dp_pkg::ST_OK;
                    n_id       = a64dp_pkg::ID_COND_CMP_BASE + {4'b0000, i_word[30], i_word[11]};
                    n_sel.rm   = 1'b1;
                    n_sel.cond = 1'b1;
                    n_sel.nzcv = 1'b1;
                end
                a64dp_pkg::GRP_COND_SEL: begin
                    if (i_word[11]) begin
                        n_status = a64dp_pkg::ST_UNALLOC;
                    end else begin
                        n_status   = a64dp_pkg::ST_OK;
                        n_id       = a64dp_pkg::ID_COND_SEL_BASE
                                     + {4'b0000, i_word[30], i_word[10]};
                        n_sel.rd   = 1'b1;
                        n_sel.rm   = 1'b1;
                        n_sel.cond = 1'b1;
                    end
                end
                a64dp_pkg::GRP_ONE_SRC: begin
                    if (op6 == a64dp_pkg::OP1_REV64 && !sf) begin
                        n_status = a64dp_pkg::ST_UNALLOC;
                    end else begin
                        n_status = a64dp_pkg::ST_OK;
                        n_id     = a64dp_pkg::ID_ONE_SRC_BASE + op6;
                        n_sel.rd = 1'b1;
                    end
                end
                a64dp_pkg::GRP_TWO_SRC: begin
                    if (op6[5:1] == a64dp_pkg::OP2_UDIV[5:1]) begin
                        n_id = a64dp_pkg::ID_DIV_BASE + (op6 - a64dp_pkg::OP2_UDIV);
                    end else if (op6[5:2] == a64dp_pkg::OP2_LSLV[5:2]) begin
                        n_id = a64dp_pkg::ID_SHIFTV_BASE + (op6 - a64dp_pkg::OP2_LSLV);
                    end else begin
                        n_id = a64dp_pkg::ID_CRC_BASE + (op6 - a64dp_pkg::OP2_CRC_LO);
                    end
                    // CRC operand size must agree with sf
                    if (crc_grp && (crc64 != sf)) begin
                        n_status = a64dp_pkg::ST_UNALLOC;
                        n_id     = a64dp_pkg::ID_NONE;
                    end else begin
                        n_status = a64dp_pkg::ST_OK;
                        n_sel.rd = 1'b1;
                        n_sel.rm = 1'b1;
                    end
                end
                a64dp_pkg::GRP_THREE_SRC: begin
                    n_status = a64dp_pkg::ST_UNALLOC;
                    case (op3)
                        a64dp_pkg::OP3_MADD: begin
                            n_status = a64dp_pkg::ST_OK;
                            n_id     = o0 ? a64dp_pkg::ID_MSUB : a64dp_pkg::ID_MADD;
                            n_sel.ra = 1'b1;
                        end
                        a64dp_pkg::OP3_SMADDL: begin
                            if (sf) begin
                                n_status = a64dp_pkg::ST_OK;
                                n_id     = o0 ? a64dp_pkg::ID_SMSUBL : a64dp_pkg::ID_SMADDL;
                                n_sel.ra = 1'b1;
                            end
                        end
                        a64dp_pkg::OP3_SMULH: begin
                            if (sf && !o0 && acc_zr) begin
                                n_status = a64dp_pkg::ST_OK;
                                n_id     = a64dp_pkg::ID_SMULH;
                            end
                        end
                        a64dp_pkg::OP3_RSVD: begin
                            if (sf) begin
                                n_status = a64dp_pkg::ST_UNSUP;
                            end
                        end
                        a64dp_pkg::OP3_UMADDL: begin
                            if (sf) begin
                                n_status = a64dp_pkg::ST_OK;
                                n_id     = o0 ? a64dp_pkg::ID_UMSUBL : a64dp_pkg::ID_UMADDL;
                                n_sel.ra = 1'b1;
                            end
                        end
                        a64dp_pkg::OP3_UMULH: begin
                            if (sf && !o0 && acc_zr) begin
                                n_status = a64dp_pkg::ST_OK;
                                n_id     = a64dp_pkg::ID_UMULH;
                            end
                        end
                        default: begin
                            n_status = a64dp_pkg::ST_UNALLOC;
                        end
                    endcase
                    if (n_status == a64dp_pkg::ST_OK) begin
                        n_sel.rd = 1'b1;
                        n_sel.rm = 1'b1;
                    end else begin
                        n_sel.ra = 1'b0;
                    end
                end
                default: begin
                    n_status = a64dp_pkg::ST_UNSUP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word   <= i_word;
            r_status <= n_status;
            r_id     <= n_id;
            r_sel    <= n_sel;
        end
    end

    assign o_valid  = r_valid;
    assign o_word   = r_word;
    assign o_status = r_status;
    assign o_id     = r_id;
    assign o_sel    = r_sel;

endmodule

`default_nettype wire

// ===== sv/a64dp_pack.sv =====
// Third stage: extracts the operand fields, zeroes all of them when status is not ok,
// and holds the result beat for the receiver. Depends on a64dp_pkg.
`default_nettype none

module a64dp_pack (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_valid,
    input  wire logic [31:0]         i_word,
    input  wire a64dp_pkg::t_status  i_status,
    input  wire logic [5:0]          i_id,
    input  wire a64dp_pkg::t_fsel    i_sel,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic [5:0]               o_id,
    output logic [4:0]               o_rd,
    output logic [4:0]               o_rn,
    output logic [4:0]               o_rm,
    output logic [4:0]               o_ra,
    output logic                     o_sf,
    output logic [1:0]               o_shift_kind,
    output logic [5:0]               o_shift_count,
    output logic [2:0]               o_extend_kind,
    output logic [3:0]               o_cond,
    output logic [3:0]               o_nzcv
);

    logic        r_valid;
    logic [1:0]  r_status;
    logic [5:0]  r_id;
    logic [4:0]  r_rd;
    logic [4:0]  r_rn;
    logic [4:0]  r_rm;
    logic [4:0]  r_ra;
    logic        r_sf;
    logic [1:0]  r_shift_kind;
    logic [5:0]  r_shift_count;
    logic [2:0]  r_extend_kind;
    logic [3:0]  r_cond;
    logic [3:0]  r_nzcv;

    logic        ok;
    logic [5:0]  n_shift_count;

    assign ok = (i_status == a64dp_pkg::ST_OK);

    always_comb begin
        n_shift_count = 6'd0;
        if (ok && i_sel.shift) begin
            n_shift_count = i_word[15:10];
        end else if (ok && i_sel.ext) begin
            n_shift_count = {3'b000, i_word[12:10]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_status      <= i_status;
            r_id          <= ok ? i_id : a64dp_pkg::ID_NONE;
            r_rd          <= (ok && i_sel.rd)    ? i_word[4:0]   : 5'd0;
            r_rn          <= ok                  ? i_word[9:5]   : 5'd0;
            r_rm          <= (ok && i_sel.rm)    ? i_word[20:16] : 5'd0;
            r_ra          <= (ok && i_sel.ra)    ? i_word[14:10] : 5'd0;
            r_sf          <= ok && i_word[31];
            r_shift_kind  <= (ok && i_sel.shift) ? i_word[23:22] : 2'd0;
            r_shift_count <= n_shift_count;
            r_extend_kind <= (ok && i_sel.ext)   ? i_word[15:13] : 3'd0;
            r_cond        <= (ok && i_sel.cond)  ? i_word[15:12] : 4'd0;
            r_nzcv        <= (ok && i_sel.nzcv)  ? i_word[3:0]   : 4'd0;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_id          = r_id;
    assign o_rd          = r_rd;
    assign o_rn          = r_rn;
    assign o_rm          = r_rm;
    assign o_ra          = r_ra;
    assign o_sf          = r_sf;
    assign o_shift_kind  = r_shift_kind;
    assign o_shift_count = r_shift_count;
    assign o_extend_kind = r_extend_kind;
    assign o_cond        = r_cond;
    assign o_nzcv        = r_nzcv;

endmodule

`default_nettype wire

// ===== sv/arm64_dp_register_decoder_unit.sv =====
// Top level of the AArch64 data-processing (register) decoder.
// Depends on a64dp_pkg, a64dp_classify, a64dp_decode and a64dp_pack.
//
// Input channel: i_valid / o_stall with i_instruction_word; one beat per word.
// Output channel: o_valid / i_stall with status, instruction number and operand
// fields; exactly one result beat per input beat, in order.
// A beat moves on a rising edge where valid is high and stall is low.
// Each accepted word passes through the classify, decode and pack registers
// before o_valid. Throughput: one word per cycle while the receiver takes beats.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up; while the receiver stalls, the result register holds and the
// stages behind it fill, o_stall rising once all three hold a beat.
// Status not ok gives instruction number 63 and every other field zero.
// Reset (i_rst_n low at a clock edge) empties all stages; no beat is lost
// or repeated across a stall.
`default_nettype none

module arm64_dp_register_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_instruction_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [5:0]       o_instruction_id,
    output logic [4:0]       o_dest_reg,
    output logic [4:0]       o_first_src_reg,
    output logic [4:0]       o_second_src_or_imm,
    output logic [4:0]       o_accum_reg,
    output logic             o_is_64bit,
    output logic [1:0]       o_shift_kind,
    output logic [5:0]       o_shift_count,
    output logic [2:0]       o_extend_kind,
    output logic [3:0]       o_cond_code,
    output logic [3:0]       o_flags_value
);

    logic                  adv1;
    logic                  adv2;
    logic                  adv3;
    logic                  v1;
    logic                  v2;
    logic [31:0]           word1;
    logic [31:0]           word2;
    a64dp_pkg::t_grp       grp1;
    logic                  fixed_ok1;
    a64dp_pkg::t_status    status2;
    logic [5:0]            id2;
    a64dp_pkg::t_fsel      sel2;

    // Advance a stage when it is empty or the next one advances
    assign adv3    = !o_valid || !i_stall;
    assign adv2    = !v2 || adv3;
    assign adv1    = !v1 || adv2;
    assign o_stall = !adv1;

    a64dp_classify u_classify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv1),
        .i_valid    (i_valid),
        .i_word     (i_instruction_word),
        .o_valid    (v1),
        .o_word     (word1),
        .o_grp      (grp1),
        .o_fixed_ok (fixed_ok1)
    );

    a64dp_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv2),
        .i_valid    (v1),
        .i_word     (word1),
        .i_grp      (grp1),
        .i_fixed_ok (fixed_ok1),
        .o_valid    (v2),
        .o_word     (word2),
        .o_status   (status2),
        .o_id       (id2),
        .o_sel      (sel2)
    );

    a64dp_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv3),
        .i_valid       (v2),
        .i_word        (word2),
        .i_status      (status2),
        .i_id          (id2),
        .i_sel         (sel2),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_id          (o_instruction_id),
        .o_rd          (o_dest_reg),
        .o_rn          (o_first_src_reg),
        .o_rm          (o_second_src_or_imm),
        .o_ra          (o_accum_reg),
        .o_sf          (o_is_64bit),
        .o_shift_kind  (o_shift_kind),
        .o_shift_count (o_shift_count),
        .o_extend_kind (o_extend_kind),
        .o_cond        (o_cond_code),
        .o_nzcv        (o_flags_value)
    );

endmodule

`default_nettype wire

// ===== verif/tb_arm64_dp_register_decoder_unit.sv =====
// Testbench for arm64_dp_register_decoder_unit: drives instruction words, predicts each
// decoded beat in-bench and compares every field in order, under random gaps and stalls.
// Depends on a64dp_pkg and the decoder RTL only.
`default_nettype none

module tb_arm64_dp_register_decoder_unit;
    import a64dp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_SLACK = 8;
    localparam int unsigned OP2_COUNT   = 18;

    localparam logic [1:0] SHIFT_RSVD = 2'b11;
    localparam logic [5:0] OP2_CRC32B = OP2_CRC_LO;
    localparam logic [5:0] OP2_CRC32X = OP2_CRC_LO + 6'd3;
    localparam logic [5:0] OP2_LAST   = OP2_CRC_LO + 6'd11;

    typedef struct packed {
        t_status    status;
        logic [5:0] id;
        logic [4:0] rd;
        logic [4:0] rn;
        logic [4:0] rm;
        logic [4:0] ra;
        logic       wide;
        logic [1:0] shift_kind;
        logic [5:0] shift_count;
        logic [2:0] extend_kind;
        logic [3:0] cond;
        logic [3:0] nzcv;
    } t_decode_fields;

    typedef struct packed {
        logic [31:0]    word;
        t_decode_fields fields;
    } t_decoded_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_instruction_word = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [5:0]  o_instruction_id;
    logic [4:0]  o_dest_reg;
    logic [4:0]  o_first_src_reg;
    logic [4:0]  o_second_src_or_imm;
    logic [4:0]  o_accum_reg;
    logic        o_is_64bit;
    logic [1:0]  o_shift_kind;
    logic [5:0]  o_shift_count;
    logic [2:0]  o_extend_kind;
    logic [3:0]  o_cond_code;
    logic [3:0]  o_flags_value;

    t_decoded_word decodes_due[$];
    int unsigned   tx_gap_max = 0;
    int unsigned   tx_burst_left = 0;
    int unsigned   rx_stall_pct = 0;
    int unsigned   stall_hold_len = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;

    arm64_dp_register_decoder_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_instruction_word  (i_instruction_word),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_instruction_id    (o_instruction_id),
        .o_dest_reg          (o_dest_reg),
        .o_first_src_reg     (o_first_src_reg),
        .o_second_src_or_imm (o_second_src_or_imm),
        .o_accum_reg         (o_accum_reg),
        .o_is_64bit          (o_is_64bit),
        .o_shift_kind        (o_shift_kind),
        .o_shift_count       (o_shift_count),
        .o_extend_kind       (o_extend_kind),
        .o_cond_code         (o_cond_code),
        .o_flags_value       (o_flags_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_decode_fields predict_decode(input logic [31:0] w);
        t_decode_fields r;
        t_status        st_keep;
        logic           sf;
        logic [5:0]     op;
        logic [4:0]     acc;
        logic           o0;
        logic           known;
        r = '0;
        r.status = ST_UNSUP;
        sf = w[31];
        op = w[15:10];
        acc = w[14:10];
        o0 = w[15];
        case (w[28:24])
            MAJ_LOGICAL: begin
                // a 32-bit form cannot shift by 32 or more
                if (!sf && op[5]) begin
                    r.status = ST_UNALLOC;
                end else begin
                    r.status = ST_OK;
                    r.id = ID_LOGICAL_BASE + {3'b000, w[30:29], w[21]};
                    {r.rd, r.rn, r.rm} = {w[4:0], w[9:5], w[20:16]};
                    r.shift_kind = w[23:22];
                    r.shift_count = op;
                end
            end
            MAJ_ADDSUB: begin
                if (w[21]) begin
                    if (w[23:22] != 2'b00 || w[12:10] > 3'd4) begin
                        r.status = ST_UNALLOC;
                    end else begin
                        r.status = ST_OK;
                        r.id = ID_ADDSUB_EXT_BASE + {4'b0000, w[30:29]};
                        {r.rd, r.rn, r.rm} = {w[4:0], w[9:5], w[20:16]};
                        r.extend_kind = w[15:13];
                        r.shift_count = {3'b000, w[12:10]};
                    end
                end else if (w[23:22] == SHIFT_RSVD || (!sf && op[5])) begin
                    r.status = ST_UNALLOC;
                end else begin
                    r.status = ST_OK;
                    r.id = ID_ADDSUB_SH_BASE + {4'b0000, w[30:29]};
                    {r.rd, r.rn, r.rm} = {w[4:0], w[9:5], w[20:16]};
                    r.shift_kind = w[23:22];
                    r.shift_count = op;
                end
            end
            MAJ_DP_MISC: begin
                case (w[23:21])
                    SUB_CARRY: begin
                        if (op == '0) begin
                            r.status = ST_OK;
                            r.id = ID_CARRY_BASE + {4'b0000, w[30:29]};
                            {r.rd, r.rn, r.rm} = {w[4:0], w[9:5], w[20:16]};
                        end
                    end
                    SUB_COND_CMP: begin
                        if (w[29] && !w[10] && !w[4]) begin
                            r.status = ST_OK;
                            r.id = ID_COND_CMP_BASE + {4'b0000, w[30], w[11]};
                            {r.rn, r.rm} = {w[9:5], w[20:16]};
                            r.cond = w[15:12];
                            r.nzcv = w[3:0];
                        end
                    end
                    SUB_COND_SEL: begin
                        if (!w[29]) begin
                            if (w[11]) begin
                                r.status = ST_UNALLOC;
                            end else begin
                                r.status = ST_OK;
                                r.id = ID_COND_SEL_BASE + {4'b0000, w[30], w[10]};
                                {r.rd, r.rn, r.rm} = {w[4:0], w[9:5], w[20:16]};
                                r.cond = w[15:12];
                            end
                        end
                    end
                    SUB_DP_SRC: begin
                        if (w[30]) begin
                            if (!w[29] && w[20:16] == '0 && op <= OP1_LAST) begin
                                if (op == OP1_REV64 && !sf) begin
                                    r.status = ST_UNALLOC;
                                end else begin
                                    r.status = ST_OK;
                                    r.id = ID_ONE_SRC_BASE + op;
                                    {r.rd, r.rn} = {w[4:0], w[9:5]};
                                end
                            end
                        end else if (!w[29]) begin
                            known = 1'b1;
                            if (op[5:1] == OP2_UDIV[5:1]) begin
                                r.id = ID_DIV_BASE + {5'b00000, op[0]};
                            end else if (op[5:2] == OP2_LSLV[5:2]) begin
                                r.id = ID_SHIFTV_BASE + {4'b0000, op[1:0]};
                            end else if (op >= OP2_CRC_LO && op <= OP2_LAST) begin
                                r.id = ID_CRC_BASE + (op - OP2_CRC_LO);
                            end else begin
                                known = 1'b0;
                            end
                            if (known) begin
                                // CRC width must agree with sf: only the X forms are 64-bit
                                if (op[5:3] == OP2_CRC_LO[5:3] && ((op[1:0] == 2'b11) != sf)) begin
                                    r.status = ST_UNALLOC;
                                end else begin
                                    r.status = ST_OK;
                                    {r.rd, r.rn, r.rm} = {w[4:0], w[9:5], w[20:16]};
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MAJ_3SRC: begin
                if (w[30:29] == 2'b00) begin
                    r.status = ST_UNALLOC;
                    case (w[23:21])
                        OP3_MADD: begin
                            r.status = ST_OK;
                            r.id = o0 ? ID_MSUB : ID_MADD;
                        end
                        OP3_SMADDL: begin
                            if (sf) begin
                                r.status = ST_OK;
                                r.id = o0 ? ID_SMSUBL : ID_SMADDL;
                            end
                        end
                        OP3_SMULH: begin
                            if (sf && !o0 && acc == REG_ZR) begin
                                r.status = ST_OK;
                                r.id = ID_SMULH;
                            end
                        end
                        OP3_RSVD: begin
                            if (sf) r.status = ST_UNSUP;
                        end
                        OP3_UMADDL: begin
                            if (sf) begin
                                r.status = ST_OK;
                                r.id = o0 ? ID_UMSUBL : ID_UMADDL;
                            end
                        end
                        OP3_UMULH: begin
                            if (sf && !o0 && acc == REG_ZR) begin
                                r.status = ST_OK;
                                r.id = ID_UMULH;
                            end
                        end
                        default: ;
                    endcase
                    if (r.status == ST_OK) begin
                        {r.rd, r.rn, r.rm} = {w[4:0], w[9:5], w[20:16]};
                        if (w[23:21] == OP3_MADD || w[23:21] == OP3_SMADDL ||
                            w[23:21] == OP3_UMADDL) begin
                            r.ra = acc;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (r.status == ST_OK) begin
            r.wide = sf;
        end else begin
            st_keep = r.status;
            r = '0;
            r.status = st_keep;
        end
        if (r.status != ST_OK) r.id = ID_NONE;
        return r;
    endfunction

    function automatic logic [5:0] two_src_op(input int unsigned idx);
        if (idx < 2) return OP2_UDIV + 6'(idx);
        else if (idx < 6) return OP2_LSLV + 6'(idx - 2);
        else return OP2_CRC_LO + 6'(idx - 6);
    endfunction

    // Mostly well-formed words for one group with random operands; unless clean is set,
    // one in eight is left loose so the reserved and unsupported corners keep turning up.
    function automatic logic [31:0] shape_word(input t_grp grp, input bit clean);
        logic [31:0] w;
        logic        tidy;
        w = $urandom;
        tidy = clean || ($urandom_range(0, 7) != 0);
        case (grp)
            GRP_LOGICAL: begin
                w[28:24] = MAJ_LOGICAL;
                if (tidy && !w[31]) w[15] = 1'b0;
            end
            GRP_ADDSUB_SH: begin
                w[28:24] = MAJ_ADDSUB;
                w[21] = 1'b0;
                if (tidy) begin
                    w[23:22] = 2'($urandom_range(0, 2));
                    if (!w[31]) w[15] = 1'b0;
                end
            end
            GRP_ADDSUB_EXT: begin
                w[28:24] = MAJ_ADDSUB;
                w[21] = 1'b1;
                if (tidy) begin
                    w[23:22] = 2'b00;
                    w[12:10] = 3'($urandom_range(0, 4));
                end
            end
            GRP_CARRY: begin
                w[28:24] = MAJ_DP_MISC;
                w[23:21] = SUB_CARRY;
                if (tidy) w[15:10] = '0;
            end
            GRP_COND_CMP: begin
                w[28:24] = MAJ_DP_MISC;
                w[23:21] = SUB_COND_CMP;
                if (tidy) {w[29], w[10], w[4]} = 3'b100;
            end
            GRP_COND_SEL: begin
                w[28:24] = MAJ_DP_MISC;
                w[23:21] = SUB_COND_SEL;
                if (tidy) {w[29], w[11]} = 2'b00;
            end
            GRP_ONE_SRC: begin
                w[28:24] = MAJ_DP_MISC;
                w[23:21] = SUB_DP_SRC;
                w[30] = 1'b1;
                if (tidy) begin
                    w[29] = 1'b0;
                    w[20:16] = '0;
                    w[15:10] = 6'($urandom_range(0, OP1_LAST));
                    if (w[15:10] == OP1_REV64) w[31] = 1'b1;
                end
            end
            GRP_TWO_SRC: begin
                w[28:24] = MAJ_DP_MISC;
                w[23:21] = SUB_DP_SRC;
                w[30] = 1'b0;
                if (tidy) begin
                    w[29] = 1'b0;
                    w[15:10] = two_src_op($urandom_range(0, OP2_COUNT - 1));
                    if (w[15:13] == OP2_CRC_LO[5:3]) w[31] = &w[11:10];
                end
            end
            GRP_THREE_SRC: begin
                w[28:24] = MAJ_3SRC;
                if (tidy) begin
                    w[30:29] = 2'b00;
                    case ($urandom_range(0, 4))
                        0: w[23:21] = OP3_MADD;
                        1: w[23:21] = OP3_SMADDL;
                        2: w[23:21] = OP3_SMULH;
                        3: w[23:21] = OP3_UMADDL;
                        default: w[23:21] = OP3_UMULH;
                    endcase
                    if (w[23:21] != OP3_MADD) w[31] = 1'b1;
                    if (w[23:21] == OP3_SMULH || w[23:21] == OP3_UMULH) begin
                        w[15] = 1'b0;
                        w[14:10] = REG_ZR;
                    end
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic t_grp random_grp();
        return t_grp'(4'($urandom_range(GRP_NONE, GRP_THREE_SRC)));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] word);
        mismatch_count++;
        $display("mismatch: word %08h: %s", word, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] word,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want), word);
    endtask

    // Offer one word, holding it while stalled; leave valid high for the next beat.
    task automatic send_word(input logic [31:0] w);
        int unsigned   gap;
        t_decoded_word entry;
        if (tx_gap_max != 0) begin
            if (tx_burst_left == 0) begin
                gap = $urandom_range(1, tx_gap_max);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                tx_burst_left = $urandom_range(1, 12);
            end
            tx_burst_left--;
        end
        i_valid <= 1'b1;
        i_instruction_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        entry.word = w;
        entry.fields = predict_decode(w);
        decodes_due.push_back(entry);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (decodes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        logic [31:0] w;
        tx_gap_max = 0;
        rx_stall_pct = 0;
        send_word('0);
        send_word('1);
        w = shape_word(GRP_LOGICAL, 1'b1);
        {w[31], w[15:10]} = {1'b1, 6'd63};
        send_word(w);
        {w[31], w[15:10]} = {1'b0, 6'd32};
        send_word(w);
        w[15:10] = 6'd31;
        send_word(w);
        w = shape_word(GRP_ADDSUB_SH, 1'b1);
        w[23:22] = SHIFT_RSVD;
        send_word(w);
        w = shape_word(GRP_ADDSUB_EXT, 1'b1);
        w[12:10] = 3'd5;
        send_word(w);
        w[12:10] = 3'd4;
        send_word(w);
        w[23:22] = 2'b01;
        send_word(w);
        w = shape_word(GRP_CARRY, 1'b1);
        send_word(w);
        w[15:10] = '1;
        send_word(w);
        w = shape_word(GRP_COND_CMP, 1'b1);
        {w[11], w[3:0]} = 5'b11111;
        send_word(w);
        w[4] = 1'b1;
        send_word(w);
        w = shape_word(GRP_COND_SEL, 1'b1);
        w[29] = 1'b1;
        send_word(w);
        {w[29], w[11]} = 2'b01;
        send_word(w);
        w = shape_word(GRP_CARRY, 1'b1);
        w[23:21] = SUB_DP_SRC | 3'b001;
        send_word(w);
        w = shape_word(GRP_ONE_SRC, 1'b1);
        {w[31], w[15:10]} = {1'b0, OP1_REV64};
        send_word(w);
        w[31] = 1'b1;
        send_word(w);
        w[15:10] = OP1_LAST + 6'd1;
        send_word(w);
        w = shape_word(GRP_TWO_SRC, 1'b1);
        {w[31], w[15:10]} = {1'b0, OP2_CRC32X};
        send_word(w);
        {w[31], w[15:10]} = {1'b1, OP2_CRC32B};
        send_word(w);
        w[15:10] = '0;
        send_word(w);
        w = shape_word(GRP_THREE_SRC, 1'b1);
        {w[31], w[23:21]} = {1'b1, OP3_RSVD};
        send_word(w);
        w[31] = 1'b0;
        send_word(w);
        {w[31], w[23:21], w[15:10]} = {1'b1, OP3_SMULH, 6'd0};
        send_word(w);
        {w[31], w[23:21]} = {1'b0, OP3_MADD};
        send_word(w);
    endtask

    task automatic test_back_to_back(input int unsigned count);
        tx_gap_max = 0;
        rx_stall_pct = 0;
        repeat (count) send_word(shape_word(random_grp(), 1'b0));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        tx_gap_max = 6;
        rx_stall_pct = 35;
        repeat (count) send_word(shape_word(random_grp(), 1'b0));
    endtask

    // Receiver holds off long enough for every stage to fill and o_stall to rise.
    task automatic test_receiver_hold_off();
        tx_gap_max = 0;
        rx_stall_pct = 0;
        stall_hold_len = 60;
        repeat (24) send_word(shape_word(random_grp(), 1'b0));
    endtask

    task automatic test_sender_pause();
        tx_gap_max = 3;
        rx_stall_pct = 50;
        repeat (20) send_word(shape_word(random_grp(), 1'b0));
        wait_for_drain();
        repeat (30) send_word(shape_word(random_grp(), 1'b0));
    endtask

    // Receiver: random stall runs, or one long hold when a test asks for it
    initial begin
        int unsigned run_left;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_hold_len != 0) begin
                i_stall <= 1'b1;
                repeat (stall_hold_len) @(posedge i_clk);
                stall_hold_len = 0;
                i_stall <= 1'b0;
                run_left = 0;
            end else if (run_left != 0) begin
                run_left--;
            end else begin
                i_stall <= (rx_stall_pct != 0) && ($urandom_range(1, 100) <= rx_stall_pct);
                run_left = $urandom_range(0, 5);
            end
        end
    end

    always @(posedge i_clk) begin
        t_decoded_word due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (decodes_due.size() == 0) begin
                report_mismatch("result beat with nothing outstanding", '0);
            end else begin
                due = decodes_due.pop_front();
                check_field("status", due.word, 32'(o_status), 32'(due.fields.status));
                check_field("id", due.word, 32'(o_instruction_id), 32'(due.fields.id));
                check_field("rd", due.word, 32'(o_dest_reg), 32'(due.fields.rd));
                check_field("rn", due.word, 32'(o_first_src_reg), 32'(due.fields.rn));
                check_field("rm", due.word, 32'(o_second_src_or_imm), 32'(due.fields.rm));
                check_field("ra", due.word, 32'(o_accum_reg), 32'(due.fields.ra));
                check_field("sf", due.word, 32'(o_is_64bit), 32'(due.fields.wide));
                check_field("shift", due.word, 32'(o_shift_kind), 32'(due.fields.shift_kind));
                check_field("amount", due.word, 32'(o_shift_count), 32'(due.fields.shift_count));
                check_field("extend", due.word, 32'(o_extend_kind), 32'(due.fields.extend_kind));
                check_field("cond", due.word, 32'(o_cond_code), 32'(due.fields.cond));
                check_field("nzcv", due.word, 32'(o_flags_value), 32'(due.fields.nzcv));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_back_to_back(100);
        test_random_traffic(420);
        test_receiver_hold_off();
        test_sender_pause();
        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/a64dp_pkg.sv
sv/a64dp_classify.sv
sv/a64dp_decode.sv
sv/a64dp_pack.sv
sv/arm64_dp_register_decoder_unit.sv
verif/tb_arm64_dp_register_decoder_unit.sv
